// File: hdl/integer_to_ascii_padded_core_defines.svh
// Assertion macros used by the checker file of the integer to ASCII block
`ifndef INTEGER_TO_ASCII_PADDED_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_PADDED_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define I2A_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset
`define I2A_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/i2a_pkg.sv
// Package with widths, ASCII constants and control types of the integer to ASCII block
package i2a_pkg;

   localparam int OP_W    = 1;
   localparam int VALUE_W = 32;
   localparam int CHAR_W  = 8;
   localparam int WIDTH_W = 5;

   // Radix select codes
   localparam logic [OP_W-1:0] OP_DEC = 1'b0;
   localparam logic [OP_W-1:0] OP_HEX = 1'b1;

   // Digit store: ten decimal digits cover 32 bits
   localparam int DIG_DEPTH = 10;
   localparam int DIG_IDX_W = $clog2(DIG_DEPTH);
   localparam int DIGIT_W   = 4;

   // Reciprocal of ten, exact for 32-bit operands with a shift of 35
   localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
   localparam int          DEC_SHIFT = 35;
   localparam logic [DIGIT_W-1:0] DEC_RADIX = 4'd10;

   localparam logic [CHAR_W-1:0] ASCII_ZERO       = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_ALPHA_BASE = 8'h60;
   localparam logic [CHAR_W-1:0] ASCII_MINUS      = 8'h2D;

   typedef struct packed {
      logic load;
      logic conv_step;
      logic emit_sign;
      logic emit_fill;
      logic emit_digit;
   } i2a_cmd_type;

   typedef struct packed {
      logic conv_done;
      logic neg;
      logic fill_zero;
      logic dig_zero;
      logic out_free;
   } i2a_sts_type;

endpackage

// File: hdl/i2a_req_if.sv
// Request channel interface: one value to convert per word
interface i2a_req_if;
   import i2a_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           op;
   logic signed [VALUE_W-1:0] value;
   logic [CHAR_W-1:0]         fill_char;
   logic [WIDTH_W-1:0]        min_width;

   modport source (output valid, op, value, fill_char, min_width, input ready);
   modport sink (input valid, op, value, fill_char, min_width, output ready);
endinterface

// File: hdl/i2a_rsp_if.sv
// Response channel interface: one ASCII character per word
interface i2a_rsp_if;
   import i2a_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_out;
   logic              last_char;

   modport source (output valid, char_out, last_char, input ready);
   modport sink (input valid, char_out, last_char, output ready);
endinterface

// File: hdl/i2a_ctrl.sv
// Controller state machine sequencing convert, sign, fill and digit phases
module i2a_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  i2a_pkg::i2a_sts_type sts,
   output i2a_pkg::i2a_cmd_type cmd
);
   import i2a_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_SIGN  = 3'd2;
   localparam logic [2:0] ST_FILL  = 3'd3;
   localparam logic [2:0] ST_DIGIT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Decode next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (sts.conv_done) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            if (!sts.neg) begin
               state_in = ST_FILL;
            end else if (sts.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_FILL;
            end
         end
         ST_FILL: begin
            if (sts.fill_zero) begin
               state_in = ST_DIGIT;
            end else if (sts.out_free) begin
               cmd.emit_fill = 1'b1;
            end
         end
         ST_DIGIT: begin
            if (sts.out_free) begin
               cmd.emit_digit = 1'b1;
               if (sts.dig_zero) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// File: hdl/i2a_datapath.sv
// Datapath: digit extraction, digit store, pad counter and output register
module i2a_datapath #(
   parameter int MAX_WIDTH = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  i2a_pkg::i2a_cmd_type         cmd,
   output i2a_pkg::i2a_sts_type         sts,
   input  logic [i2a_pkg::OP_W-1:0]     req_op,
   input  logic [i2a_pkg::VALUE_W-1:0]  req_value,
   input  logic [i2a_pkg::CHAR_W-1:0]   req_fill_char,
   input  logic [i2a_pkg::WIDTH_W-1:0]  req_min_width,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [i2a_pkg::CHAR_W-1:0]   rsp_char_out,
   output logic                         rsp_last_char
);
   import i2a_pkg::*;

   localparam logic [WIDTH_W-1:0] WIDTH_LIMIT = WIDTH_W'(MAX_WIDTH);

   logic [VALUE_W-1:0]   mag_ff;
   logic [OP_W-1:0]      op_ff;
   logic                 neg_ff;
   logic [CHAR_W-1:0]    fill_char_ff;
   logic [WIDTH_W-1:0]   width_ff;
   logic [DIGIT_W-1:0]   dig_ff [DIG_DEPTH];
   logic [DIG_IDX_W-1:0] ndig_ff;
   logic [DIG_IDX_W-1:0] dig_idx_ff;
   logic [WIDTH_W-1:0]   fill_cnt_ff;
   logic                 rsp_valid_ff;
   logic [CHAR_W-1:0]    char_ff;
   logic                 last_ff;

   logic [2*VALUE_W-1:0] dec_prod;
   logic [VALUE_W-1:0]   dec_quot;
   logic [VALUE_W-1:0]   dec_times10;
   logic [DIGIT_W-1:0]   dec_rem;
   logic [VALUE_W-1:0]   step_quot;
   logic [DIGIT_W-1:0]   step_rem;
   logic [DIG_IDX_W-1:0] ndig_next;
   logic [WIDTH_W-1:0]   ndig_next_w;
   logic [WIDTH_W-1:0]   fill_calc;
   logic [DIGIT_W-1:0]   cur_digit;
   logic [CHAR_W-1:0]    digit_char;
   logic [CHAR_W-1:0]    char_in;
   logic                 out_free;

   // Divide by ten through the reciprocal, remainder by shift-and-add
   assign dec_prod    = 64'(mag_ff) * 64'(DEC_RECIP);
   assign dec_quot    = VALUE_W'(dec_prod >> DEC_SHIFT);
   assign dec_times10 = (dec_quot << 3) + (dec_quot << 1);
   assign dec_rem     = DIGIT_W'(mag_ff - dec_times10);

   // Select decimal or hex digit step
   always_comb begin
      if (op_ff == OP_HEX) begin
         step_quot = {4'b0, mag_ff[VALUE_W-1:4]};
         step_rem  = mag_ff[DIGIT_W-1:0];
      end else begin
         step_quot = dec_quot;
         step_rem  = dec_rem;
      end
   end

   // Pad count once the digit count is known
   assign ndig_next   = ndig_ff + 1'b1;
   assign ndig_next_w = WIDTH_W'(ndig_next);
   assign fill_calc   = (width_ff > ndig_next_w) ? (width_ff - ndig_next_w) : '0;

   // Map the current digit to ASCII
   assign cur_digit  = dig_ff[dig_idx_ff];
   assign digit_char = (cur_digit < DEC_RADIX) ? (ASCII_ZERO + CHAR_W'(cur_digit))
                     : (ASCII_ALPHA_BASE + CHAR_W'(cur_digit) - CHAR_W'(9));

   always_comb begin
      if (cmd.emit_sign) begin
         char_in = ASCII_MINUS;
      end else if (cmd.emit_fill) begin
         char_in = fill_char_ff;
      end else begin
         char_in = digit_char;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   assign sts.conv_done = (step_quot == '0);
   assign sts.neg       = neg_ff;
   assign sts.fill_zero = (fill_cnt_ff == '0);
   assign sts.dig_zero  = (dig_idx_ff == '0);
   assign sts.out_free  = out_free;

   // Capture the word and run the digit loop
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff        <= req_op;
         neg_ff       <= req_value[VALUE_W-1];
         mag_ff       <= req_value[VALUE_W-1] ? (VALUE_W'(0) - req_value) : req_value;
         fill_char_ff <= req_fill_char;
         width_ff     <= (req_min_width > WIDTH_LIMIT) ? WIDTH_LIMIT : req_min_width;
      end else if (cmd.conv_step) begin
         mag_ff           <= step_quot;
         dig_ff[ndig_ff]  <= step_rem;
      end
   end

   // Count digits, pad characters and the read index
   always_ff @(posedge clock) begin
      if (reset) begin
         ndig_ff     <= '0;
         dig_idx_ff  <= '0;
         fill_cnt_ff <= '0;
      end else begin
         if (cmd.load) begin
            ndig_ff <= '0;
         end else if (cmd.conv_step) begin
            ndig_ff <= ndig_next;
            if (step_quot == '0) begin
               dig_idx_ff  <= ndig_ff;
               fill_cnt_ff <= fill_calc;
            end
         end
         if (cmd.emit_fill) begin
            fill_cnt_ff <= fill_cnt_ff - 1'b1;
         end
         if (cmd.emit_digit && (dig_idx_ff != '0)) begin
            dig_idx_ff <= dig_idx_ff - 1'b1;
         end
      end
   end

   // Output register: load a character or drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_sign || cmd.emit_fill || cmd.emit_digit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_sign || cmd.emit_fill || cmd.emit_digit) begin
         char_ff <= char_in;
         last_ff <= cmd.emit_digit && (dig_idx_ff == '0);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_out  = char_ff;
   assign rsp_last_char = last_ff;
endmodule

// File: hdl/integer_to_ascii_padded_core.sv
// Top level of the integer to ASCII converter with padding
//
//   channel   dir  words                        handshake
//   req_chan  in   op, value, fill_char, width  valid/ready, one value per word
//   rsp_chan  out  char_out, last_char          valid/ready, one character per word
//
// An item runs through the convert, sign, fill and digit phases, with 1 to 10 digits
// and pad characters up to the width; the pace is set by the one-digit-per-cycle
// divide-by-ten unit and the single output register, which sends one character a
// cycle while rsp_chan does not stall.
// Reset is synchronous and clears the controller and the output valid.
// A stall on rsp_chan holds the pending character and pauses the sequence.
module integer_to_ascii_padded_core #(
   parameter int MAX_WIDTH = 24
) (
   input  logic       clock,
   input  logic       reset,
   i2a_req_if.sink    req_chan,
   i2a_rsp_if.source  rsp_chan
);
   import i2a_pkg::*;

   i2a_cmd_type cmd;
   i2a_sts_type sts;

   i2a_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   i2a_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_op        (req_chan.op),
      .req_value     (req_chan.value),
      .req_fill_char (req_chan.fill_char),
      .req_min_width (req_chan.min_width),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_char_out  (rsp_chan.char_out),
      .rsp_last_char (rsp_chan.last_char)
   );
endmodule

// File: hdl/i2a_checker.sv
// Port-level checker for the integer to ASCII block and its bind
`include "integer_to_ascii_padded_core_defines.svh"

module i2a_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [i2a_pkg::CHAR_W-1:0]  rsp_char_out,
   input logic                        rsp_last_char
);
   import i2a_pkg::*;

   // A stalled character holds
   `I2A_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_char_out) && $stable(rsp_last_char), "stalled rsp word changed")

   // One conversion at a time: no new word right after one is taken
   `I2A_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready, "req taken while a conversion runs")

   // Only the final character may still wait while a new word is taken
   `I2A_ASSERT_SAME(a_mid_text, clock, reset, rsp_valid && !rsp_last_char, !req_ready, "req ready in the middle of a text")
endmodule

bind integer_to_ascii_padded_core i2a_checker u_i2a_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_char_out  (rsp_chan.char_out),
   .rsp_last_char (rsp_chan.last_char)
);

// File: tb/sv/tb_integer_to_ascii_padded_core.sv
// Self-checking testbench: directed and random conversions, each character compared in order
module tb_integer_to_ascii_padded_core;
   timeunit 1ns;
   timeprecision 1ps;
   import i2a_pkg::*;

   localparam int SAT_WIDTH   = 24;
   localparam int N_DIR       = 20;
   localparam int N_RAND      = 440;
   localparam int IDLE_PCT    = 37;
   localparam int DRAIN_CYC   = 60;
   localparam int CYCLE_LIMIT = 600000;

   typedef logic [CHAR_W-1:0] char_type;

   typedef struct {
      logic [OP_W-1:0]           op;
      logic signed [VALUE_W-1:0] value;
      char_type                  fill;
      logic [WIDTH_W-1:0]        width;
      string                     golden;
   } conv_row_type;

   typedef struct packed {
      char_type ch;
      logic     last;
   } char_word_type;

   logic clock;
   logic reset = 1'b1;

   i2a_req_if req_bus ();
   i2a_rsp_if rsp_bus ();

   integer_to_ascii_padded_core #(
      .MAX_WIDTH(SAT_WIDTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   conv_row_type  conv_q[$];
   char_word_type char_due_q[$];
   conv_row_type  cur_row;
   int            next_idx    = 0;
   int            n_words_in  = 0;
   int            n_chars_out = 0;
   int            n_errors    = 0;
   int            n_hex       = 0;
   int            n_neg       = 0;
   int            n_sat       = 0;
   int            cycle_cnt   = 0;
   logic          calm;

   // Drop idling on both sides for a stretch in the middle of the run
   assign calm = (n_words_in >= 200) && (n_words_in < 280);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) cycle_cnt <= cycle_cnt + 1;

   // Expected characters of one conversion: sign, fill, then digits, last one flagged
   function automatic void predict_chars(input conv_row_type row);
      char_type    text[$];
      logic [31:0] mag;
      logic [31:0] radix;
      logic [3:0]  digs [16];
      logic [3:0]  d;
      int          nd;
      int          w;
      int          i;
      if (row.golden.len() != 0) begin
         for (i = 0; i < row.golden.len(); i++) text.push_back(char_type'(row.golden[i]));
      end else begin
         radix = (row.op == OP_HEX) ? 32'd16 : 32'd10;
         mag = row.value;
         if (row.value[VALUE_W-1]) mag = 32'd0 - mag;
         w = (row.width > SAT_WIDTH) ? SAT_WIDTH : int'(row.width);
         nd = 0;
         // collect digits least significant first
         do begin
            digs[nd] = 4'(mag % radix);
            mag = mag / radix;
            nd++;
         end while (mag != 0);
         if (row.value[VALUE_W-1]) text.push_back(ASCII_MINUS);
         for (i = nd; i < w; i++) text.push_back(row.fill);
         for (i = nd - 1; i >= 0; i--) begin
            d = digs[i];
            if (d < 4'd10) text.push_back(ASCII_ZERO + char_type'(d));
            else text.push_back(ASCII_ALPHA_BASE + char_type'(d) - char_type'(9));
         end
      end
      for (i = 0; i < text.size(); i++) char_due_q.push_back('{text[i], i == text.size() - 1});
   endfunction

   // Present request words, hold a stalled word, predict on each accepted word
   always @(posedge clock) begin : req_drive
      conv_row_type row;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_chars(cur_row);
            n_words_in++;
            if (cur_row.op == OP_HEX) n_hex++;
            if (cur_row.value < 0) n_neg++;
            if (cur_row.width > SAT_WIDTH) n_sat++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (next_idx < conv_q.size() && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               row = conv_q[next_idx];
               next_idx++;
               cur_row = row;
               req_bus.valid     <= 1'b1;
               req_bus.op        <= row.op;
               req_bus.value     <= row.value;
               req_bus.fill_char <= row.fill;
               req_bus.min_width <= row.width;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Stall the character channel at random
   always @(posedge clock) begin
      rsp_bus.ready <= !reset && (calm || $urandom_range(0, 99) >= IDLE_PCT);
   end

   // Compare each accepted character word with the oldest expectation
   always @(posedge clock) begin : rsp_check
      char_word_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         n_chars_out++;
         if (char_due_q.size() == 0) begin
            $error("unexpected character word: char_out=%02h last_char=%0b",
                   rsp_bus.char_out, rsp_bus.last_char);
            n_errors++;
         end else begin
            due = char_due_q.pop_front();
            if (rsp_bus.char_out !== due.ch) begin
               $error("char_out: expected %02h, got %02h", due.ch, rsp_bus.char_out);
               n_errors++;
            end
            if (rsp_bus.last_char !== due.last) begin
               $error("last_char: expected %0b, got %0b", due.last, rsp_bus.last_char);
               n_errors++;
            end
         end
      end
   end

   // Abort a run that hangs
   initial begin : watchdog
      wait (cycle_cnt >= CYCLE_LIMIT);
      $display("integer_to_ascii_padded_core: mismatch");
      $finish;
   end

   initial begin : main
      conv_row_type              dir_tab [N_DIR];
      conv_row_type              row;
      int                        pow10 [10];
      logic signed [VALUE_W-1:0] v;
      int                        i;
      int                        k;

      req_bus.valid     = 1'b0;
      req_bus.op        = OP_DEC;
      req_bus.value     = '0;
      req_bus.fill_char = '0;
      req_bus.min_width = '0;
      rsp_bus.ready     = 1'b0;

      pow10 = '{1, 10, 100, 1000, 10000, 100000, 1000000, 10000000, 100000000, 1000000000};

      // Directed rows: typed text where obvious, predictor elsewhere
      dir_tab = '{
         '{OP_DEC, 32'sd0,          8'h20, 5'd0,  "0"},
         '{OP_DEC, 32'sd0,          "*",   5'd5,  "****0"},
         '{OP_DEC, 32'sh7fffffff,   " ",   5'd0,  "2147483647"},
         '{OP_DEC, 32'sh80000000,   " ",   5'd0,  "-2147483648"},
         '{OP_HEX, 32'sh80000000,   " ",   5'd0,  "-80000000"},
         '{OP_HEX, 32'sh7fffffff,   " ",   5'd0,  "7fffffff"},
         '{OP_HEX, -32'sd1,         "0",   5'd4,  "-0001"},
         '{OP_DEC, -32'sd1,         " ",   5'd0,  "-1"},
         '{OP_HEX, 32'sh00abcdef,   " ",   5'd8,  "  abcdef"},
         '{OP_DEC, 32'sd12345,      "#",   5'd3,  "12345"},
         '{OP_DEC, 32'sd1000000000, "z",   5'd10, "1000000000"},
         '{OP_HEX, 32'sh10,         " ",   5'd0,  "10"},
         '{OP_DEC, 32'sd7,          ".",   5'd31, ""},
         '{OP_HEX, -32'sh7fffffff,  8'hFF, 5'd31, ""},
         '{OP_DEC, -32'sd5,         8'h00, 5'd24, ""},
         '{OP_DEC, 32'sd42,         "_",   5'd25, ""},
         '{OP_HEX, 32'sd0,          "x",   5'd24, ""},
         '{OP_DEC, 32'sh80000000,   "0",   5'd31, ""},
         '{OP_HEX, 32'sh0fedcba9,   8'h80, 5'd1,  ""},
         '{OP_DEC, -32'sd999999999, "0",   5'd12, ""}
      };
      for (i = 0; i < N_DIR; i++) conv_q.push_back(dir_tab[i]);

      // Random rows over several value classes
      for (i = 0; i < N_RAND; i++) begin
         row.op = ($urandom_range(0, 1) == 0) ? OP_DEC : OP_HEX;
         case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2: begin
               v = $urandom_range(0, 300);
               if ($urandom_range(0, 1) == 1) v = -v;
            end
            3: begin
               case ($urandom_range(0, 5))
                  0: v = 32'sd0;
                  1: v = 32'sd1;
                  2: v = -32'sd1;
                  3: v = 32'sh7fffffff;
                  4: v = 32'sh80000000;
                  default: v = 32'sh80000001;
               endcase
            end
            4: begin
               // land on and next to a digit-count boundary
               if (row.op == OP_HEX) begin
                  k = $urandom_range(0, 7);
                  v = 32'sd1 <<< (4 * k);
               end else begin
                  k = $urandom_range(0, 9);
                  v = pow10[k];
               end
               v = v + $urandom_range(0, 2) - 1;
               if ($urandom_range(0, 1) == 1) v = -v;
            end
            default: begin
               v = $urandom >> $urandom_range(0, 31);
               if ($urandom_range(0, 1) == 1) v = -v;
            end
         endcase
         row.value  = v;
         row.fill   = char_type'($urandom_range(0, 255));
         row.width  = WIDTH_W'(($urandom_range(0, 9) == 0) ? $urandom_range(25, 31)
                                                            : $urandom_range(0, 24));
         row.golden = "";
         conv_q.push_back(row);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request word, then every character, then a quiet tail
      do @(negedge clock); while (n_words_in < conv_q.size());
      while (char_due_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYC) @(negedge clock);

      $display("ran %0d conversions: %0d hex, %0d negative, %0d with width above the limit",
               n_words_in, n_hex, n_neg, n_sat);
      $display("checked %0d character words, %0d errors", n_chars_out, n_errors);
      if (n_errors == 0) begin
         $display("integer_to_ascii_padded_core: match");
      end else begin
         $display("integer_to_ascii_padded_core: mismatch");
      end
      $finish;
   end

endmodule
